FILE: src/ibm_pkg.sv
// Shared constants for the inverse bilinear mapping pipeline.
// No dependencies; used by ibm_mul and inverse_bilinear_mapping.
package ibm_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // multiplier operand B is consumed this many bits per stage
  localparam int MUL_CHUNK       = 16;
  // near-parallel test: LIN_RATIO * |qa| <= |qb|
  localparam int LIN_RATIO       = 10000;
  localparam int LIN_RATIO_W     = 14;
endpackage

FILE: src/ibm_mul.sv
// Pipelined signed multiplier, one MUL_CHUNK slice of operand b per stage.
// Depends on ibm_pkg. Stages: magnitudes, partial sums, signed output.
module ibm_mul #(
  parameter int WA = 69,
  parameter int WB = 69,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [WA+WB-1:0] prod,
  output logic [SW-1:0]        out_side
);
  localparam int CH = ibm_pkg::MUL_CHUNK;
  localparam int NC = (WB + CH - 1) / CH;
  localparam int PW = WA + WB;
  localparam int BP = NC * CH;

  logic          v    [NC+1];
  logic [WA-1:0] am   [NC];
  logic [BP-1:0] bm   [NC];
  logic [PW-1:0] acc  [NC+1];
  logic          neg  [NC+1];
  logic [SW-1:0] sd   [NC+1];

  // stage 0: magnitudes and product sign
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am[0]  <= a[WA-1] ? $unsigned(-a) : $unsigned(a);
      bm[0]  <= BP'(b[WB-1] ? $unsigned(-b) : $unsigned(b));
      acc[0] <= '0;
      neg[0] <= a[WA-1] ^ b[WB-1];
      sd[0]  <= in_side;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic [WA+CH-1:0] pp;
    assign pp = am[k] * bm[k][k*CH +: CH];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k+1] <= acc[k] + (PW'(pp) << (k*CH));
        neg[k+1] <= neg[k];
        sd[k+1]  <= sd[k];
      end
    end

    if (k < NC-1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          am[k+1] <= am[k];
          bm[k+1] <= bm[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= neg[NC] ? -$signed(acc[NC]) : $signed(acc[NC]);
      out_side <= sd[NC];
    end
  end
endmodule

FILE: src/ibm_sqrt.sv
// Pipelined integer square root, one root bit per stage (RW stages).
// Standalone; floor(sqrt(rad)) with rad of 2*RW bits.
module ibm_sqrt #(
  parameter int RW = 86,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   out_side
);
  logic            vv   [RW+1];
  logic [RW+2:0]   rem  [RW+1];
  logic [RW-1:0]   rt   [RW+1];
  logic [2*RW-1:0] radv [RW+1];
  logic [SW-1:0]   sd   [RW+1];

  assign vv[0]   = in_valid;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign radv[0] = rad;
  assign sd[0]   = in_side;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] cat;
    logic [RW+2:0] trial;
    logic          ge;
    // remainder never exceeds 2*root, so its low RW+1 bits hold it
    assign cat   = {rem[k][RW:0], radv[k][2*RW-1 -: 2]};
    assign trial = (RW+3)'({rt[k], 2'b01});
    assign ge    = cat >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[k+1] <= 1'b0;
      end else if (en) begin
        vv[k+1] <= vv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? cat - trial : cat;
        rt[k+1]   <= {rt[k][RW-2:0], ge};
        radv[k+1] <= radv[k] << 2;
        sd[k+1]   <= sd[k];
      end
    end
  end

  assign out_valid = vv[RW];
  assign root      = rt[RW];
  assign out_side  = sd[RW];
endmodule

FILE: src/ibm_div.sv
// Pipelined floor divider for quotients in 0..2^(F+1)-1, one bit per stage.
// Standalone; flags negative results, zero divisors and overrange quotients.
module ibm_div #(
  parameter int W  = 110,
  parameter int F  = 16,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  input  logic                in_fail,
  input  logic [SW-1:0]       in_side,
  output logic                out_valid,
  output logic [F:0]          quot,
  output logic                out_fail,
  output logic [SW-1:0]       out_side
);
  localparam int CW = W + F + 1;

  logic          va;
  logic [W-1:0]  an;
  logic [W-1:0]  dn_a;
  logic          neg_nz;
  logic          zd;
  logic          fa;
  logic [SW-1:0] sda;

  logic          v  [F+2];
  logic [W-1:0]  rem[F+2];
  logic [W-1:0]  dd [F+2];
  logic [F:0]    q  [F+2];
  logic          fl [F+2];
  logic [SW-1:0] sd [F+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      va   <= in_valid;
      v[0] <= va;
    end
  end

  // floor of a negative nonzero quotient is below zero: fail early
  always_ff @(posedge clk) begin
    if (en) begin
      an     <= num[W-1] ? $unsigned(-num) : $unsigned(num);
      dn_a   <= den[W-1] ? $unsigned(-den) : $unsigned(den);
      neg_nz <= (num[W-1] ^ den[W-1]) && (num != '0);
      zd     <= den == '0;
      fa     <= in_fail;
      sda    <= in_side;
      rem[0] <= an;
      dd[0]  <= dn_a;
      q[0]   <= '0;
      fl[0]  <= fa | neg_nz | zd | (CW'(an) >= (CW'(dn_a) << (F+1)));
      sd[0]  <= sda;
    end
  end

  for (genvar j = 0; j <= F; j++) begin : g_stage
    logic [CW-1:0] ds;
    logic          ge;
    assign ds = CW'(dd[j]) << (F-j);
    assign ge = CW'(rem[j]) >= ds;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= ge ? W'(CW'(rem[j]) - ds) : rem[j];
        dd[j+1]  <= dd[j];
        q[j+1]   <= {q[j][F-1:0], ge};
        fl[j+1]  <= fl[j];
        sd[j+1]  <= sd[j];
      end
    end
  end

  assign out_valid = v[F+1];
  assign quot      = q[F+1];
  assign out_fail  = fl[F+1];
  assign out_side  = sd[F+1];
endmodule

FILE: src/inverse_bilinear_mapping.sv
// Inverse bilinear mapping: finds s,t of a point inside a planar quad.
// Depends on ibm_pkg, ibm_mul, ibm_sqrt and ibm_div.
//
// Input channel s_*: one beat carries a point and four quad corners, all
// signed fixed point with FRAC_BITS fraction bits. Output channel m_*: one
// beat per input beat, in order, with inside_res and the unsigned s and t
// (1 << FRAC_BITS means 1.0); s and t read 0 when inside_res is 0.
// Throughput: one beat per cycle while the output queue is not full. Most
// stages lie in the square-root chain (one root bit per stage) and the
// two divider chains (one quotient bit per stage).
// All stages move on one shared enable. A two-entry output queue sits behind
// the last stage; the pipeline holds only when that queue is full, so input
// beats keep being taken while one result waits on a stalled receiver.
// Nothing is dropped or repeated under stalls on either side.
// Reset (rst, synchronous) empties the pipeline and the output queue.
module inverse_bilinear_mapping #(
  parameter int COORD_WIDTH = ibm_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ibm_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // point_x, point_z, corner_a_x, corner_a_z, corner_b_x, corner_b_z,
  // corner_c_x, corner_c_z, corner_d_x, corner_d_z (lowest first)
  input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // inside_res, s_coord, t_coord (lowest first)
  output logic [((2*FRAC_BITS+3+7)/8)*8-1:0] m_tdata
);
  localparam int C    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OW   = 2*(F+1) + 1;
  localparam int OBW  = ((OW+7)/8)*8;
  localparam int MW   = C + 2;
  localparam int DFW  = C + 1;
  localparam int PW   = 2*C + 3;
  localparam int QW   = 2*C + 5;
  localparam int GW   = 2*MW + 6*DFW;
  localparam int DW   = 2*QW + 3;
  localparam int NRAD = DW - 1 + 2*F;
  localparam int RTW  = (NRAD + 1) / 2;
  localparam int RADW = 2*RTW;
  localparam int TW   = QW + 2*F + 4;
  localparam int SPW  = C + F + 4;
  localparam int SDW  = C + F + 5;
  localparam int SNW  = C + 2*F + 6;
  localparam int XW   = GW + 3*QW + 2;
  localparam int LW   = QW + ibm_pkg::LIN_RATIO_W;

  logic       en;
  logic [1:0] fcnt;

  assign en       = fcnt != 2'd2;
  assign s_tready = en && !rst;

  // ---------------- stage 0: differences ----------------
  logic signed [C-1:0] px, pz, ax, az, bx, bz, cx, cz, dx, dz;
  assign px = s_tdata[0*C +: C];
  assign pz = s_tdata[1*C +: C];
  assign ax = s_tdata[2*C +: C];
  assign az = s_tdata[3*C +: C];
  assign bx = s_tdata[4*C +: C];
  assign bz = s_tdata[5*C +: C];
  assign cx = s_tdata[6*C +: C];
  assign cz = s_tdata[7*C +: C];
  assign dx = s_tdata[8*C +: C];
  assign dz = s_tdata[9*C +: C];

  logic v0, v1, v2, v3, vd, vt, va, vb, vc;
  logic signed [MW-1:0]  mx0, mz0;
  logic signed [DFW-1:0] ux0, uz0, vx0, vz0, wx0, wz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx0 <= MW'(ax) - MW'(bx) - MW'(cx) + MW'(dx);
      mz0 <= MW'(az) - MW'(bz) - MW'(cz) + MW'(dz);
      ux0 <= DFW'(bx) - DFW'(ax);
      uz0 <= DFW'(bz) - DFW'(az);
      vx0 <= DFW'(cx) - DFW'(ax);
      vz0 <= DFW'(cz) - DFW'(az);
      wx0 <= DFW'(px) - DFW'(ax);
      wz0 <= DFW'(pz) - DFW'(az);
    end
  end

  // ---------------- stage 1: coefficient products ----------------
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5, p6, p7;
  logic [GW-1:0]        g1, g2, g3;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= vz0 * mx0;
      p1 <= vx0 * mz0;
      p2 <= mz0 * wx0;
      p3 <= mx0 * wz0;
      p4 <= vz0 * ux0;
      p5 <= uz0 * vx0;
      p6 <= uz0 * wx0;
      p7 <= ux0 * wz0;
      g1 <= {mx0, mz0, ux0, uz0, vx0, vz0, wx0, wz0};
    end
  end

  // ---------------- stage 2: quadratic coefficients ----------------
  logic signed [QW-1:0] qa2, qb2, qc2;

  always_ff @(posedge clk) begin
    if (en) begin
      qa2 <= QW'(p0) - QW'(p1);
      qb2 <= QW'(p2) - QW'(p3) + QW'(p4) - QW'(p5);
      qc2 <= QW'(p6) - QW'(p7);
      g2  <= g1;
    end
  end

  // ---------------- stage 3: branch tests ----------------
  logic [QW-1:0] qa_m, qb_m, qc_m;
  logic [LW-1:0] qa_sc;
  logic signed [QW-1:0] qa3, qb3, qc3;
  logic                 lin3, linf3;

  assign qa_m  = qa2[QW-1] ? $unsigned(-qa2) : $unsigned(qa2);
  assign qb_m  = qb2[QW-1] ? $unsigned(-qb2) : $unsigned(qb2);
  assign qc_m  = qc2[QW-1] ? $unsigned(-qc2) : $unsigned(qc2);
  assign qa_sc = LW'(qa_m) * LW'(ibm_pkg::LIN_RATIO);

  always_ff @(posedge clk) begin
    if (en) begin
      qa3   <= qa2;
      qb3   <= qb2;
      qc3   <= qc2;
      lin3  <= qa_sc <= LW'(qb_m);
      linf3 <= {qb_m, 1'b0} <= (QW+1)'(qc_m);
      g3    <= g2;
    end
  end

  // ---------------- discriminant products ----------------
  logic                   vm;
  logic signed [2*QW-1:0] sq, pq;
  logic [GW-1:0]          gm;
  logic [3*QW+1:0]        xm;

  ibm_mul #(.WA(QW), .WB(QW), .SW(GW)) u_mul_bb (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .a(qb3), .b(qb3), .in_side(g3),
    .out_valid(vm), .prod(sq), .out_side(gm)
  );

  ibm_mul #(.WA(QW), .WB(QW), .SW(3*QW+2)) u_mul_ac (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .a(qa3), .b(qc3), .in_side({qa3, qb3, qc3, lin3, linf3}),
    .out_valid(), .prod(pq), .out_side(xm)
  );

  // ---------------- discriminant, clamped at zero ----------------
  logic signed [DW-1:0] disc;
  logic [NRAD-1:0]      radn;
  logic [RADW-1:0]      rad_d;
  logic [XW-1:0]        xd;

  assign disc = DW'(sq) - (DW'(pq) <<< 2);
  assign radn = {disc[DW-2:0], {(2*F){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_d <= disc[DW-1] ? '0 : RADW'(radn);
      xd    <= {gm, xm};
    end
  end

  // ---------------- square root ----------------
  logic           vr;
  logic [RTW-1:0] root;
  logic [XW-1:0]  xr;

  ibm_sqrt #(.RW(RTW), .SW(XW)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(vd),
    .rad(rad_d), .in_side(xd),
    .out_valid(vr), .root(root), .out_side(xr)
  );

  // ---------------- t numerator and denominator ----------------
  logic signed [QW-1:0] qa_r, qb_r, qc_r;
  logic                 lin_r, linf_r;
  logic signed [TW-1:0] tnum_c, tden_c, tnum, tden;
  logic                 tfi;
  logic [GW-1:0]        gt;

  assign linf_r = xr[0];
  assign lin_r  = xr[1];
  assign qc_r   = xr[2 +: QW];
  assign qb_r   = xr[2+QW +: QW];
  assign qa_r   = xr[2+2*QW +: QW];

  always_comb begin
    if (lin_r) begin
      tnum_c = -(TW'(qc_r) <<< F);
      tden_c = TW'(qb_r);
    end else if (qb_r[QW-1] || qb_r == '0) begin
      tnum_c = -(TW'(qb_r) <<< F) + $signed(TW'(root));
      tden_c = TW'(qa_r) <<< 1;
    end else begin
      tnum_c = -(TW'(qc_r) <<< (2*F+1));
      tden_c = (TW'(qb_r) <<< F) + $signed(TW'(root));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (en) begin
      vt <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tnum <= tnum_c;
      tden <= tden_c;
      tfi  <= lin_r & linf_r;
      gt   <= xr[2+3*QW +: GW];
    end
  end

  // ---------------- t divider ----------------
  logic          vq;
  logic [F:0]    tq_d;
  logic          tf_d;
  logic [GW-1:0] gq;

  ibm_div #(.W(TW), .F(F), .SW(GW)) u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(vt),
    .num(tnum), .den(tden), .in_fail(tfi), .in_side(gt),
    .out_valid(vq), .quot(tq_d), .out_fail(tf_d), .out_side(gq)
  );

  // ---------------- s terms ----------------
  logic signed [MW-1:0]  mx_q, mz_q;
  logic signed [DFW-1:0] ux_q, uz_q, vx_q, vz_q, wx_q, wz_q;
  logic signed [F+1:0]   tq_s;

  assign wz_q = gq[0 +: DFW];
  assign wx_q = gq[DFW +: DFW];
  assign vz_q = gq[2*DFW +: DFW];
  assign vx_q = gq[3*DFW +: DFW];
  assign uz_q = gq[4*DFW +: DFW];
  assign ux_q = gq[5*DFW +: DFW];
  assign mz_q = gq[6*DFW +: MW];
  assign mx_q = gq[6*DFW+MW +: MW];
  assign tq_s = $signed({1'b0, tq_d});

  logic signed [SPW-1:0] pmx, pmz, pvx, pvz;
  logic signed [DFW-1:0] ux_a, uz_a, wx_a, wz_a;
  logic [F:0]            tq_a, tq_b, tq_c;
  logic                  tf_a, tf_b, tf_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= vq;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pmx  <= mx_q * tq_s;
      pmz  <= mz_q * tq_s;
      pvx  <= vx_q * tq_s;
      pvz  <= vz_q * tq_s;
      ux_a <= ux_q;
      uz_a <= uz_q;
      wx_a <= wx_q;
      wz_a <= wz_q;
      tq_a <= tq_d;
      tf_a <= tf_d | (tq_d > (F+1)'(1 << F));
    end
  end

  logic signed [SDW-1:0] denx, denz, numx, numz;

  always_ff @(posedge clk) begin
    if (en) begin
      denx <= SDW'(pmx) + (SDW'(ux_a) <<< F);
      denz <= SDW'(pmz) + (SDW'(uz_a) <<< F);
      numx <= (SDW'(wx_a) <<< F) - SDW'(pvx);
      numz <= (SDW'(wz_a) <<< F) - SDW'(pvz);
      tq_b <= tq_a;
      tf_b <= tf_a;
    end
  end

  // larger-magnitude denominator; z wins a tie
  logic [SDW-1:0]        denx_m, denz_m;
  logic signed [SNW-1:0] snum, sden;
  logic                  pick_x;

  assign denx_m = denx[SDW-1] ? $unsigned(-denx) : $unsigned(denx);
  assign denz_m = denz[SDW-1] ? $unsigned(-denz) : $unsigned(denz);
  assign pick_x = denx_m > denz_m;

  always_ff @(posedge clk) begin
    if (en) begin
      snum <= pick_x ? (SNW'(numx) <<< F) : (SNW'(numz) <<< F);
      sden <= pick_x ? SNW'(denx) : SNW'(denz);
      tq_c <= tq_b;
      tf_c <= tf_b;
    end
  end

  // ---------------- s divider ----------------
  logic       vs;
  logic [F:0] sq_d;
  logic       sf_d;
  logic [F:0] tq_o;

  ibm_div #(.W(SNW), .F(F), .SW(F+1)) u_div_s (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc),
    .num(snum), .den(sden), .in_fail(tf_c), .in_side(tq_c),
    .out_valid(vs), .quot(sq_d), .out_fail(sf_d), .out_side(tq_o)
  );

  logic          hit;
  logic [OW-1:0] res;

  assign hit = !sf_d && (sq_d <= (F+1)'(1 << F));
  assign res = hit ? {tq_o, sq_d, 1'b1} : '0;

  // ---------------- output queue ----------------
  logic [OW-1:0] fdat [2];
  logic          wp, rp;
  logic          push, pop;

  assign push     = en && vs;
  assign m_tvalid = fcnt != 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = OBW'(fdat[rp]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fcnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fdat[wp] <= res;
    end
  end
endmodule
